### hdl/slc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slc_pkg;
  localparam int unsigned LayerW  = 8;
  localparam int unsigned ExpertW = 16;
  localparam int unsigned TagW    = 24;
  localparam int unsigned CntW    = 32;
  localparam int unsigned ClkW    = 64;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 7;

  localparam logic [CfgIdxW-1:0] RegSlotsInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLruMode    = 1'b1;

  localparam logic [31:0] LcgMul   = 32'd1664525;
  localparam logic [31:0] LcgAdd   = 32'd1013904223;
  localparam logic [31:0] SeedInit = 32'h9e3779b9;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_READ, ST_SCAN, ST_FREE, ST_LCG, ST_MOD, ST_SRD, ST_SCMP,
    ST_VREAD, ST_COMMIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;      // latch request, bump clock
    logic look;       // tag lookup on current scan slot
    logic free_chk;   // free-slot check: lowest free slot below n
    logic scan_inc;
    logic lcg_step;
    logic mod_step;
    logic samp_rd;
    logic samp_cmp;
    logic vic_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic hit_found;
    logic free_found;
    logic mod_done;
    logic samp_last;
  } sts_t;

  typedef struct packed {
    logic                hit;
    logic [IdxOutW-1:0]  slot_index;
    logic                fetch_issued;
    logic                evicted;
    logic [LayerW-1:0]   evicted_layer;
    logic [ExpertW-1:0]  evicted_expert;
    logic                data_ready;
    logic [CntW-1:0]     hit_total;
    logic [CntW-1:0]     miss_total;
    logic [CntW-1:0]     eviction_total;
  } res_t;

  typedef struct packed {
    logic [LayerW-1:0]  layer;
    logic [ExpertW-1:0] expert;
    logic               fetch_ok;
  } req_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_t;
endpackage
`default_nettype wire

### hdl/slc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface slc_req_if;
  logic            valid;
  logic            ready;
  slc_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slc_res_if;
  logic            valid;
  logic            ready;
  slc_pkg::res_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slc_cfg_if;
  logic            valid;
  logic            ready;
  slc_pkg::cfg_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/slc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module slc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire slc_pkg::sts_t sts_i,
  output slc_pkg::cmd_t      cmd_o
);
  slc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      slc_pkg::ST_IDLE:  if (in_valid_i) state_d = slc_pkg::ST_LOOK;
      slc_pkg::ST_LOOK: begin
        if (sts_i.n_zero) state_d = slc_pkg::ST_COMMIT;
        else state_d = slc_pkg::ST_READ;
      end
      slc_pkg::ST_READ:  state_d = slc_pkg::ST_SCAN;
      slc_pkg::ST_SCAN: begin
        if (sts_i.hit_found) state_d = slc_pkg::ST_COMMIT;
        else if (sts_i.scan_last) state_d = slc_pkg::ST_FREE;
        else state_d = slc_pkg::ST_READ;
      end
      slc_pkg::ST_FREE: begin
        if (sts_i.free_found) state_d = slc_pkg::ST_VREAD;
        else state_d = slc_pkg::ST_LCG;
      end
      slc_pkg::ST_LCG:   state_d = slc_pkg::ST_MOD;
      slc_pkg::ST_MOD:   if (sts_i.mod_done) state_d = slc_pkg::ST_SRD;
      slc_pkg::ST_SRD:   state_d = slc_pkg::ST_SCMP;
      slc_pkg::ST_SCMP: begin
        if (sts_i.samp_last) state_d = slc_pkg::ST_VREAD;
        else state_d = slc_pkg::ST_LCG;
      end
      slc_pkg::ST_VREAD:  state_d = slc_pkg::ST_COMMIT;
      slc_pkg::ST_COMMIT: state_d = slc_pkg::ST_OUT;
      slc_pkg::ST_OUT:    if (out_ready_i) state_d = slc_pkg::ST_IDLE;
      default:            state_d = slc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      slc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      slc_pkg::ST_SCAN: begin
        cmd_o.look = 1'b1;
        cmd_o.scan_inc = 1'b1;
      end
      slc_pkg::ST_FREE:   cmd_o.free_chk = 1'b1;
      slc_pkg::ST_LCG:    cmd_o.lcg_step = 1'b1;
      slc_pkg::ST_MOD:    cmd_o.mod_step = 1'b1;
      slc_pkg::ST_SRD:    cmd_o.samp_rd = 1'b1;
      slc_pkg::ST_SCMP:   cmd_o.samp_cmp = 1'b1;
      slc_pkg::ST_VREAD:  cmd_o.vic_rd = 1'b1;
      slc_pkg::ST_COMMIT: cmd_o.commit = 1'b1;
      slc_pkg::ST_OUT:    out_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o) else $error("commit not followed by result");
endmodule
`default_nettype wire

### hdl/slc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module slc_dp #(
  parameter int unsigned SLOTS   = 64,
  parameter int unsigned SAMPLES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire slc_pkg::req_t req_i,
  input  wire slc_pkg::cmd_t cmd_i,
  input  wire logic [slc_pkg::CfgDatW-1:0] slots_cfg_i,
  input  wire logic          lru_i,
  output slc_pkg::sts_t      sts_o,
  output slc_pkg::res_t      res_o
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned SW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned MW = (NW > 7) ? NW : 7;

  // slot record memory: tag, use count, last use
  logic [slc_pkg::TagW-1:0] tag_mem [SLOTS];
  logic [slc_pkg::CntW-1:0] use_mem [SLOTS];
  logic [slc_pkg::ClkW-1:0] lu_mem  [SLOTS];
  logic [SLOTS-1:0] valid_q;

  slc_pkg::req_t req_q;
  logic [slc_pkg::ClkW-1:0] clock_q;
  logic [31:0] seed_q;
  logic [slc_pkg::CntW-1:0] hits_q, miss_q, evs_q;
  logic [NW-1:0] n_q;
  logic [IW-1:0] scan_q;
  logic hit_q;
  logic [IW-1:0] idx_q;
  logic [slc_pkg::TagW-1:0] rd_tag_q;
  logic [slc_pkg::CntW-1:0] rd_use_q;
  logic [slc_pkg::ClkW-1:0] rd_lu_q;
  logic [IW-1:0] rd_addr;
  logic [slc_pkg::CntW-1:0] best_use_q;
  logic [slc_pkg::ClkW-1:0] best_lu_q;
  logic [IW-1:0] best_q;
  logic [SW-1:0] samp_q;
  // restoring modulo: remainder over 32 bit steps
  logic [31:0] dvd_q;
  logic [NW:0] rem_q;
  logic [5:0] bit_q;
  logic rd_valid_q;
  slc_pkg::res_t res_q;
  slc_pkg::res_t res_d;

  logic [NW-1:0] n_eff;
  logic [MW-1:0] cfg_ext;
  logic [SLOTS-1:0] free_mask;
  logic free_any;
  logic [IW-1:0] free_idx;
  logic [NW:0] rem_sh, rem_nx;
  logic better;
  logic [slc_pkg::TagW-1:0] key;

  assign key = {req_q.layer, req_q.expert};
  assign cfg_ext = MW'(slots_cfg_i);
  assign n_eff = (cfg_ext > MW'(SLOTS)) ? NW'(SLOTS) : NW'(cfg_ext);

  always_comb begin
    free_mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      free_mask[i] = !valid_q[i] && (NW'(i) < n_q);
    end
    free_any = |free_mask;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) free_idx = IW'(i);
    end
  end

  assign rem_sh = {rem_q[NW-1:0], dvd_q[31]};
  assign rem_nx = (rem_sh >= (NW+1)'(n_q)) ? rem_sh - (NW+1)'(n_q) : rem_sh;

  always_comb begin
    if (lru_i) begin
      better = rd_lu_q < best_lu_q;
    end else begin
      better = (rd_use_q < best_use_q) ||
               ((rd_use_q == best_use_q) && (rd_lu_q < best_lu_q));
    end
    if (samp_q == '0) better = 1'b1;
  end

  always_comb begin
    rd_addr = scan_q;
    if (cmd_i.samp_rd) rd_addr = rem_q[IW-1:0];
    else if (cmd_i.vic_rd || cmd_i.commit) rd_addr = idx_q;
  end

  // result and counters after this request
  always_comb begin
    res_d = '0;
    res_d.hit_total = hits_q;
    res_d.miss_total = miss_q + 1'b1;
    res_d.eviction_total = evs_q;
    if (n_q != '0) begin
      res_d.slot_index = slc_pkg::IdxOutW'(idx_q);
      if (hit_q) begin
        res_d.hit = 1'b1;
        res_d.data_ready = 1'b1;
        res_d.hit_total = hits_q + 1'b1;
        res_d.miss_total = miss_q;
      end else begin
        res_d.fetch_issued = 1'b1;
        res_d.data_ready = req_q.fetch_ok;
        if (valid_q[idx_q]) begin
          res_d.evicted = 1'b1;
          res_d.evicted_layer = rd_tag_q[slc_pkg::TagW-1 -: slc_pkg::LayerW];
          res_d.evicted_expert = rd_tag_q[slc_pkg::ExpertW-1:0];
          res_d.eviction_total = evs_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= tag_mem[rd_addr];
    rd_use_q <= use_mem[rd_addr];
    rd_lu_q  <= lu_mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
    if (cmd_i.commit && n_q != '0) begin
      if (hit_q) begin
        use_mem[idx_q] <= rd_use_q + 1'b1;
        lu_mem[idx_q]  <= clock_q;
      end else if (req_q.fetch_ok) begin
        tag_mem[idx_q] <= key;
        use_mem[idx_q] <= slc_pkg::CntW'(1);
        lu_mem[idx_q]  <= clock_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      req_q   <= '0;
      clock_q <= '0;
      seed_q  <= slc_pkg::SeedInit;
      hits_q  <= '0;
      miss_q  <= '0;
      evs_q   <= '0;
      n_q     <= '0;
      scan_q  <= '0;
      hit_q   <= 1'b0;
      idx_q   <= '0;
      samp_q  <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      best_q  <= '0;
      best_use_q <= '0;
      best_lu_q  <= '0;
      res_q   <= '0;
    end else begin
      if (cmd_i.start) begin
        req_q   <= req_i;
        clock_q <= clock_q + 1'b1;
        n_q     <= n_eff;
        scan_q  <= '0;
        hit_q   <= 1'b0;
        idx_q   <= '0;
        samp_q  <= '0;
      end
      if (cmd_i.look) begin
        if (rd_valid_q && rd_tag_q == key) begin
          hit_q <= 1'b1;
          idx_q <= scan_q;
        end
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.free_chk) idx_q <= free_idx;
      if (cmd_i.lcg_step) begin
        seed_q <= seed_q * slc_pkg::LcgMul + slc_pkg::LcgAdd;
        dvd_q  <= seed_q * slc_pkg::LcgMul + slc_pkg::LcgAdd;
        rem_q  <= '0;
        bit_q  <= '0;
      end
      if (cmd_i.mod_step) begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[30:0], 1'b0};
        bit_q <= bit_q + 1'b1;
      end
      if (cmd_i.samp_cmp) begin
        if (better) begin
          best_q <= rem_q[IW-1:0];
          idx_q  <= rem_q[IW-1:0];
          best_use_q <= rd_use_q;
          best_lu_q  <= rd_lu_q;
        end
        samp_q <= samp_q + 1'b1;
      end
      if (cmd_i.commit) begin
        res_q  <= res_d;
        hits_q <= res_d.hit_total;
        miss_q <= res_d.miss_total;
        evs_q  <= res_d.eviction_total;
        if (n_q != '0 && !hit_q) valid_q[idx_q] <= req_q.fetch_ok;
      end
    end
  end

  always_comb begin
    sts_o.n_zero     = (n_q == '0);
    sts_o.scan_last  = (NW'(scan_q) == n_q - 1'b1) || (scan_q == IW'(SLOTS - 1));
    sts_o.hit_found  = rd_valid_q && (rd_tag_q == key);
    sts_o.free_found = free_any;
    sts_o.mod_done   = (bit_q == 6'd31);
    sts_o.samp_last  = (samp_q == SW'(SAMPLES - 1));
  end
  assign res_o = res_q;

  a_vic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.samp_cmp |-> (rem_q < (NW+1)'(n_q))) else $error("sample out of range");
  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> clock_q == $past(clock_q) + 1'b1) else $error("clock skip");
  a_best_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.samp_cmp |=> idx_q == best_q) else $error("victim mismatch");
endmodule
`default_nettype wire

### hdl/sampled_lru_lfru_slot_cache.sv
// Flow: a lookup scans the n slots in use one by one; when no slot hits and none is free,
// the victim is chosen from SAMPLES pseudo-random samples (32-step remainder unit each).
// Throughput: one request at a time; the next is taken after the result transfer.
// Reset: all slots free, clock and counters zero, seed 0x9e3779b9, 64 slots, LFRU mode.
`timescale 1ns / 1ps
`default_nettype none
module sampled_lru_lfru_slot_cache #(
  parameter int unsigned SLOTS   = 64,
  parameter int unsigned SAMPLES = 16
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  slc_req_if.sink    req,
  slc_res_if.source  res,
  slc_cfg_if.sink    cfg
);
  slc_pkg::cmd_t cmd;
  slc_pkg::sts_t sts;
  logic [slc_pkg::CfgDatW-1:0] slots_q;
  logic lru_q;
  logic busy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= slc_pkg::CfgDatW'(64);
      lru_q   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        slc_pkg::RegSlotsInUse: slots_q <= cfg.payload.data;
        slc_pkg::RegLruMode:    lru_q <= cfg.payload.data[0];
        default: begin
        end
      endcase
    end
  end

  slc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (req.valid),
    .in_ready_o  (busy),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );
  assign req.ready = busy;

  slc_dp #(.SLOTS(SLOTS), .SAMPLES(SAMPLES)) u_dp (
    .clk_i,
    .rst_ni,
    .req_i       (req.payload),
    .cmd_i       (cmd),
    .slots_cfg_i (slots_q),
    .lru_i       (lru_q),
    .sts_o       (sts),
    .res_o       (res.payload)
  );
endmodule
`default_nettype wire
